// ----- rtl/espi_pkg.sv -----
// Shared widths, register indexes, sequencer states and multiplier request type.
`default_nettype none

package espi_pkg;

  localparam int unsigned CntW  = 16;
  localparam int unsigned SpdW  = 16;
  localparam int unsigned ErrW  = 17;
  localparam int unsigned GainW = 16;
  localparam int unsigned ProdW = 34;
  localparam int unsigned AccW  = 40;
  localparam int unsigned LimW  = 15;
  localparam int unsigned UW    = 43;
  localparam int unsigned RegAddrW = 2;

  localparam logic [GainW-1:0] PropGainRst   = 16'd256;
  localparam logic [GainW-1:0] IntGainTsRst  = 16'd1638;
  localparam logic [GainW-1:0] CountsToPuRst = 16'd20480;
  localparam logic [LimW-1:0]  OutLimitRst   = 15'd16384;

  typedef enum logic [RegAddrW-1:0] {
    REG_PROP_GAIN    = 2'd0,
    REG_INT_GAIN_TS  = 2'd1,
    REG_COUNTS_TO_PU = 2'd2,
    REG_OUT_LIMIT    = 2'd3
  } espi_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPEED,
    ST_ERR,
    ST_INT,
    ST_ACC,
    ST_OUT,
    ST_DONE
  } espi_state_e;

  typedef struct packed {
    logic                    en;
    logic signed [ErrW-1:0]  a;
    logic [GainW-1:0]        b;
  } espi_mul_req_t;

endpackage

`default_nettype wire

// ----- rtl/encoder_speed_pi_loop.sv -----
// Top level of the encoder speed PI loop with clamping anti-windup.
//
// One input item per speed-loop tick arrives on the s_axis channel: the
// encoder count and the speed reference in tdata, the enable and closed-loop
// flags in tuser. One result item leaves on the m_axis channel: the torque
// current reference in tdata and the clamp flag in tuser.
// Gains and the output limit are written through the cfg port; the user must
// write them only while idle, as the block itself does not enforce it. An
// active item steps through the speed, error, integral, accumulate, output and
// done states; one multiplier is shared for the speed scaling, the integral
// increment and the proportional term, one product per step. A disabled or
// open-loop item clears the integral and goes to the done state with a zero
// result. The input is ready again on the edge that loads the output
// register. A new item is taken once the previous result has been moved into
// the output register, so up to one result waits while the next item runs.
// When the receiver stalls, the finished result holds in the sequencer until
// the output register frees. Reset restores the register defaults, clears
// the integral and the last count, and empties the output register.
`default_nettype none

module encoder_speed_pi_loop import espi_pkg::*; (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  // [15:0] position_count, [31:16] speed_ref
  input  wire  [31:0]          s_axis_tdata,
  // [0] enable, [1] closed_loop
  input  wire  [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  // [15:0] torque_current_ref
  output logic [15:0]          m_axis_tdata,
  // [0] limited
  output logic                 m_axis_tuser,
  input  wire                  cfg_we_i,
  input  wire  [RegAddrW-1:0]  cfg_addr_i,
  input  wire  [GainW-1:0]     cfg_wdata_i
);

  espi_state_e state_q, state_d;

  logic [GainW-1:0] prop_gain_q, int_gain_ts_q, counts_to_pu_q;
  logic [LimW-1:0]  out_limit_q;

  logic [CntW-1:0]         last_count_q;
  logic signed [SpdW-1:0]  ref_q;
  logic signed [CntW-1:0]  delta_q;
  logic signed [ErrW-1:0]  err_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  accn_q;
  logic signed [SpdW-1:0]  res_q;
  logic                    clamp_q;

  logic                    out_valid_q;
  logic [15:0]             out_data_q;
  logic                    out_lim_q;

  espi_mul_req_t           mul_req;
  logic signed [ProdW-1:0] prod;

  logic                    in_acc;
  logic                    active;
  logic [CntW-1:0]         delta_d;
  logic signed [ProdW-1:0] speed_wide;
  logic signed [SpdW-1:0]  speed_sat;
  logic signed [ErrW-1:0]  err_d;
  logic signed [AccW:0]    acc_sum;
  logic signed [AccW-1:0]  acc_sat;
  logic signed [UW-1:0]    u_val;
  logic signed [UW-1:0]    lim_pos;
  logic signed [UW-1:0]    lim_neg;
  logic                    clamp_hi;
  logic                    clamp_lo;
  logic                    out_free;

  espi_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign active        = s_axis_tuser[0] && s_axis_tuser[1];
  assign out_free      = !out_valid_q || m_axis_tready;
  assign delta_d       = s_axis_tdata[CntW-1:0] - last_count_q;

  assign speed_wide = prod >>> 8;
  always_comb begin
    if (speed_wide > $signed(ProdW'(32767))) begin
      speed_sat = 16'sh7fff;
    end else if (speed_wide < -$signed(ProdW'(32768))) begin
      speed_sat = -16'sh8000;
    end else begin
      speed_sat = speed_wide[SpdW-1:0];
    end
  end
  assign err_d = {ref_q[SpdW-1], ref_q} - {speed_sat[SpdW-1], speed_sat};

  assign acc_sum = {acc_q[AccW-1], acc_q} + {{(AccW+1-ProdW){prod[ProdW-1]}}, prod};
  always_comb begin
    if (acc_sum[AccW] != acc_sum[AccW-1]) begin
      acc_sat = acc_sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[AccW-1:0];
    end
  end

  assign u_val = {{(UW-ProdW-8){prod[ProdW-1]}}, prod, 8'b0}
               + {{(UW-AccW){accn_q[AccW-1]}}, accn_q};
  assign lim_pos  = {{(UW-LimW-16){1'b0}}, out_limit_q, 16'b0};
  assign lim_neg  = -lim_pos;
  assign clamp_hi = u_val > lim_pos;
  assign clamp_lo = u_val < lim_neg;

  always_comb begin
    state_d   = state_q;
    mul_req   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = active ? ST_SPEED : ST_DONE;
        end
      end
      ST_SPEED: begin
        mul_req.en = 1'b1;
        mul_req.a  = {delta_q[CntW-1], delta_q};
        mul_req.b  = counts_to_pu_q;
        state_d    = ST_ERR;
      end
      ST_ERR: begin
        state_d = ST_INT;
      end
      ST_INT: begin
        mul_req.en = 1'b1;
        mul_req.a  = err_q;
        mul_req.b  = int_gain_ts_q;
        state_d    = ST_ACC;
      end
      ST_ACC: begin
        mul_req.en = 1'b1;
        mul_req.a  = err_q;
        mul_req.b  = prop_gain_q;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q    <= PropGainRst;
      int_gain_ts_q  <= IntGainTsRst;
      counts_to_pu_q <= CountsToPuRst;
      out_limit_q    <= OutLimitRst;
    end else if (cfg_we_i) begin
      unique case (espi_reg_e'(cfg_addr_i))
        REG_PROP_GAIN:    prop_gain_q    <= cfg_wdata_i;
        REG_INT_GAIN_TS:  int_gain_ts_q  <= cfg_wdata_i;
        REG_COUNTS_TO_PU: counts_to_pu_q <= cfg_wdata_i;
        REG_OUT_LIMIT:    out_limit_q    <= cfg_wdata_i[LimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
      acc_q        <= '0;
    end else begin
      if (in_acc) begin
        if (active) begin
          last_count_q <= s_axis_tdata[CntW-1:0];
        end else begin
          acc_q <= '0;
        end
      end
      if (state_q == ST_OUT && !(clamp_hi || clamp_lo)) begin
        acc_q <= accn_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ref_q   <= s_axis_tdata[31:16];
      delta_q <= delta_d;
      res_q   <= '0;
      clamp_q <= 1'b0;
    end
    if (state_q == ST_ERR) begin
      err_q <= err_d;
    end
    if (state_q == ST_ACC) begin
      accn_q <= acc_sat;
    end
    if (state_q == ST_OUT) begin
      clamp_q <= clamp_hi || clamp_lo;
      if (clamp_hi) begin
        res_q <= {1'b0, out_limit_q};
      end else if (clamp_lo) begin
        res_q <= -$signed({1'b0, out_limit_q});
      end else begin
        res_q <= u_val[31:16];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_data_q <= res_q;
      out_lim_q  <= clamp_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_lim_q;

`ifndef SYNTH
  a_lim_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      ($signed(m_axis_tdata) == $signed({1'b0, out_limit_q}) ||
       $signed(m_axis_tdata) == -$signed({1'b0, out_limit_q})))
    else $error("clamped result is not at the output limit");

  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata) <= $signed({1'b0, out_limit_q}) &&
       $signed(m_axis_tdata) >= -$signed({1'b0, out_limit_q})))
    else $error("result lies outside the output limit");

  a_off_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !active) |=> (acc_q == '0 && state_q == ST_DONE))
    else $error("disabled item did not clear the integral");

  a_hold_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !active) |=> $stable(last_count_q))
    else $error("disabled item changed the last count");
`endif

endmodule

`default_nettype wire

// ----- rtl/espi_mul.sv -----
// Shared signed-by-unsigned multiplier with a registered product.
`default_nettype none

module espi_mul import espi_pkg::*; (
  input  wire                          clk_i,
  input  espi_mul_req_t                req_i,
  output logic signed [ProdW-1:0]      prod_o
);

  logic signed [ProdW-1:0] a_ext;
  logic signed [ProdW-1:0] b_ext;
  logic signed [ProdW-1:0] prod_d;
  logic signed [ProdW-1:0] prod_q;

  assign a_ext  = {{(ProdW-ErrW){req_i.a[ErrW-1]}}, req_i.a};
  assign b_ext  = {{(ProdW-GainW){1'b0}}, req_i.b};
  assign prod_d = a_ext * b_ext;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire
